// File: rtl/core/twt_pkg.sv
`default_nettype none
package twt_pkg;

	localparam int DEPTH      = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int STAMP_W    = 32;
	localparam int PIX_W      = 12;
	localparam int SUM_W      = PIX_W + CNT_W;
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
	localparam int TGT_W      = 14;
	localparam int OUT_CNT_W  = 5;

	// frame_width / 5 is taken as (frame_width * 3277) >> 14, exact for 12-bit widths.
	localparam int RECIP5     = 3277;
	localparam int RECIP_SH   = 14;
	localparam int LIM_W      = 10;
	localparam int LIMN_W     = LIM_W + CNT_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd1;
	localparam logic [PIX_W-1:0]     FRAME_WIDTH_RST  = 12'd640;
	localparam logic [STAMP_W-1:0]   WINDOW_TICKS_RST = 32'd1000000;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [PIX_W-1:0]   left_x;
		logic [PIX_W-1:0]   obj_width;
	} in_t;

	typedef struct packed {
		logic signed [TGT_W-1:0] target;
		logic                    found;
		logic [OUT_CNT_W-1:0]    kept_count;
		logic [OUT_CNT_W-1:0]    inlier_count;
	} out_t;

	typedef struct packed {
		logic load;
		logic append;
		logic drop;
		logic walk_start;
		logic sum_step;
		logic limit;
		logic limn;
		logic test_step;
		logic div_start;
		logic div_sel;
		logic take_qx;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic expired;
		logic walk_last;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/twt_div.sv
`default_nettype none
module twt_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [twt_pkg::SUM_W-1:0]      dividend,
	input  wire logic [twt_pkg::CNT_W-1:0]      divisor,
	output logic                                done,
	output logic [twt_pkg::SUM_W-1:0]           quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [twt_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [twt_pkg::CNT_W-1:0]         rem_q;
	logic [twt_pkg::SUM_W-1:0]         quo_q;
	logic [twt_pkg::CNT_W:0]           trial;
	logic                              fits;

	// Restoring division, one quotient bit per cycle, MSB first.
	assign trial = {rem_q, quo_q[twt_pkg::SUM_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= twt_pkg::DIV_CNT_W'(twt_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == twt_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= twt_pkg::CNT_W'(trial - {1'b0, divisor});
			end else begin
				rem_q <= twt_pkg::CNT_W'(trial);
			end
			quo_q <= {quo_q[twt_pkg::SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// File: rtl/core/twt_dp.sv
`default_nettype none
module twt_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire twt_pkg::in_t                      in_data,
	input  wire logic                              cfg_we,
	input  wire logic [twt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [twt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire twt_pkg::cmd_t                     cmd,
	output twt_pkg::sts_t                          sts,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output twt_pkg::out_t                          out_data
);

	function automatic logic [twt_pkg::IDX_W-1:0] next_idx(
		input logic [twt_pkg::IDX_W-1:0] idx
	);
		if (idx == twt_pkg::IDX_W'(twt_pkg::DEPTH - 1)) begin
			return '0;
		end
		return idx + 1'b1;
	endfunction

	logic [twt_pkg::PIX_W-1:0]    fw_q;
	logic [twt_pkg::STAMP_W-1:0]  win_q;
	twt_pkg::in_t                 cur_q;

	logic [twt_pkg::STAMP_W-1:0]  mem_stamp_q [twt_pkg::DEPTH];
	logic [twt_pkg::PIX_W-1:0]    mem_x_q     [twt_pkg::DEPTH];
	logic [twt_pkg::PIX_W-1:0]    mem_w_q     [twt_pkg::DEPTH];

	logic [twt_pkg::IDX_W-1:0]    oldest_q;
	logic [twt_pkg::CNT_W-1:0]    count_q;
	logic [twt_pkg::IDX_W-1:0]    ptr_q;
	logic [twt_pkg::CNT_W-1:0]    k_q;
	logic [twt_pkg::SUM_W-1:0]    sum_q;
	logic [twt_pkg::LIM_W-1:0]    lim_q;
	logic [twt_pkg::LIMN_W-1:0]   limn_q;
	logic [twt_pkg::SUM_W-1:0]    sx_q;
	logic [twt_pkg::SUM_W-1:0]    sw_q;
	logic [twt_pkg::CNT_W-1:0]    ni_q;
	logic [twt_pkg::SUM_W-1:0]    qx_q;
	twt_pkg::out_t                out_q;
	logic                         out_valid_q;

	logic [twt_pkg::CNT_W:0]      tail_sum;
	logic [twt_pkg::IDX_W-1:0]    tail;
	logic [twt_pkg::STAMP_W-1:0]  age;
	logic [twt_pkg::PIX_W-1:0]    cur_x;
	logic [twt_pkg::SUM_W-1:0]    nx;
	logic [twt_pkg::SUM_W:0]      dev;
	logic [twt_pkg::SUM_W-1:0]    dev_abs;
	logic                         inlier;
	logic [2*twt_pkg::PIX_W-1:0]  fw_prod;
	logic                         div_done;
	logic [twt_pkg::SUM_W-1:0]    quotient;
	logic [twt_pkg::SUM_W-1:0]    target_sum;

	// Ring slot after the newest entry; equals the oldest slot when the store is full.
	assign tail_sum = (twt_pkg::CNT_W + 1)'(oldest_q) + (twt_pkg::CNT_W + 1)'(count_q);
	assign tail     = (tail_sum >= (twt_pkg::CNT_W + 1)'(twt_pkg::DEPTH))
	                ? twt_pkg::IDX_W'(tail_sum - (twt_pkg::CNT_W + 1)'(twt_pkg::DEPTH))
	                : twt_pkg::IDX_W'(tail_sum);

	assign age   = cur_q.stamp - mem_stamp_q[oldest_q];
	assign cur_x = mem_x_q[ptr_q];

	assign nx      = twt_pkg::SUM_W'(count_q) * twt_pkg::SUM_W'(cur_x);
	assign dev     = {1'b0, nx} - {1'b0, sum_q};
	assign dev_abs = dev[twt_pkg::SUM_W] ? twt_pkg::SUM_W'(-dev) : twt_pkg::SUM_W'(dev);
	assign inlier  = dev_abs < twt_pkg::SUM_W'(limn_q);

	assign fw_prod = (2 * twt_pkg::PIX_W)'(fw_q) * (2 * twt_pkg::PIX_W)'(twt_pkg::RECIP5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q        <= twt_pkg::FRAME_WIDTH_RST;
			win_q       <= twt_pkg::WINDOW_TICKS_RST;
			oldest_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					twt_pkg::REG_FRAME_WIDTH:  fw_q  <= twt_pkg::PIX_W'(cfg_data);
					twt_pkg::REG_WINDOW_TICKS: win_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.append) begin
				if (count_q == twt_pkg::CNT_W'(twt_pkg::DEPTH)) begin
					oldest_q <= next_idx(oldest_q);
				end else begin
					count_q <= count_q + 1'b1;
				end
			end else if (cmd.drop) begin
				oldest_q <= next_idx(oldest_q);
				count_q  <= count_q - 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= in_data;
		end
		if (cmd.append) begin
			mem_stamp_q[tail] <= cur_q.stamp;
			mem_x_q[tail]     <= cur_q.left_x;
			mem_w_q[tail]     <= cur_q.obj_width;
			sum_q             <= '0;
		end
		if (cmd.walk_start) begin
			ptr_q <= oldest_q;
			k_q   <= '0;
		end
		if (cmd.sum_step) begin
			sum_q <= sum_q + twt_pkg::SUM_W'(cur_x);
			ptr_q <= next_idx(ptr_q);
			k_q   <= k_q + 1'b1;
		end
		if (cmd.limit) begin
			lim_q <= twt_pkg::LIM_W'(fw_prod >> twt_pkg::RECIP_SH);
			sx_q  <= '0;
			sw_q  <= '0;
			ni_q  <= '0;
		end
		if (cmd.limn) begin
			limn_q <= twt_pkg::LIMN_W'(lim_q) * twt_pkg::LIMN_W'(count_q);
		end
		if (cmd.test_step) begin
			if (inlier) begin
				sx_q <= sx_q + twt_pkg::SUM_W'(cur_x);
				sw_q <= sw_q + twt_pkg::SUM_W'(mem_w_q[ptr_q]);
				ni_q <= ni_q + 1'b1;
			end
			ptr_q <= next_idx(ptr_q);
			k_q   <= k_q + 1'b1;
		end
		if (cmd.take_qx) begin
			qx_q <= quotient;
		end
		if (cmd.emit) begin
			out_q.found        <= ni_q != '0;
			out_q.kept_count   <= twt_pkg::OUT_CNT_W'(count_q);
			out_q.inlier_count <= twt_pkg::OUT_CNT_W'(ni_q);
			if (ni_q != '0) begin
				out_q.target <= signed'(twt_pkg::TGT_W'(target_sum));
			end else begin
				out_q.target <= '1;
			end
		end
	end

	assign target_sum = qx_q + (quotient >> 1);

	twt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_sel ? sw_q : sx_q),
		.divisor  (ni_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign sts.expired   = (count_q != '0) && (age > win_q);
	assign sts.walk_last = k_q == (count_q - 1'b1);
	assign sts.div_done  = div_done;
	assign sts.out_busy  = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// File: rtl/core/twt_ctrl.sv
`default_nettype none
module twt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire twt_pkg::sts_t    sts,
	output twt_pkg::cmd_t         cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_APPEND    = 4'd1;
	localparam logic [3:0] S_EXPIRE    = 4'd2;
	localparam logic [3:0] S_SUM       = 4'd3;
	localparam logic [3:0] S_LIMIT     = 4'd4;
	localparam logic [3:0] S_LIMN      = 4'd5;
	localparam logic [3:0] S_TEST      = 4'd6;
	localparam logic [3:0] S_DIVX_GO   = 4'd7;
	localparam logic [3:0] S_DIVX_WAIT = 4'd8;
	localparam logic [3:0] S_DIVW_GO   = 4'd9;
	localparam logic [3:0] S_DIVW_WAIT = 4'd10;
	localparam logic [3:0] S_FINISH    = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_APPEND;
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d    = S_EXPIRE;
			end
			S_EXPIRE: begin
				// Drop one stale entry per cycle from the oldest end.
				if (sts.expired) begin
					cmd.drop = 1'b1;
				end else begin
					cmd.walk_start = 1'b1;
					state_d        = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.walk_last) begin
					state_d = S_LIMIT;
				end
			end
			S_LIMIT: begin
				cmd.limit = 1'b1;
				state_d   = S_LIMN;
			end
			S_LIMN: begin
				cmd.limn       = 1'b1;
				cmd.walk_start = 1'b1;
				state_d        = S_TEST;
			end
			S_TEST: begin
				cmd.test_step = 1'b1;
				if (sts.walk_last) begin
					state_d = S_DIVX_GO;
				end
			end
			S_DIVX_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVX_WAIT;
			end
			S_DIVX_WAIT: begin
				if (sts.div_done) begin
					cmd.take_qx = 1'b1;
					state_d     = S_DIVW_GO;
				end
			end
			S_DIVW_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = S_DIVW_WAIT;
			end
			S_DIVW_WAIT: begin
				if (sts.div_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/windowed_outlier_rejecting_tracker_top.sv
// Channel    Signals                         Direction  Beat
// input      in_valid, in_stall, in_data     in         one detection (stamp, left_x, obj_width)
// output     out_valid, out_stall, out_data  out        one result (target, found, counts)
// config     cfg_we, cfg_index, cfg_data     in         one register write, no handshake
//
// A new beat is accepted only once the previous one has been fully processed and its result
// handed to the output register; in_stall is high in every state but idle.
// The store is walked one entry per cycle for expiry, for the sum and for the inlier test, and
// a one-bit-per-cycle divider runs twice, once for each of the two averages.
// Reset clears the store to empty and loads the register defaults; entry contents are not cleared.
// A result waits in the output register while the next detection is taken and processed.
`default_nettype none
module windowed_outlier_rejecting_tracker_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire twt_pkg::in_t                      in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output twt_pkg::out_t                          out_data,
	input  wire logic                              cfg_we,
	input  wire logic [twt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [twt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	twt_pkg::cmd_t cmd;
	twt_pkg::sts_t sts;

	twt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	twt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// File: bench/windowed_outlier_rejecting_tracker_top_tb.sv
`default_nettype none
module windowed_outlier_rejecting_tracker_top_tb;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	twt_pkg::in_t                   in_data = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	twt_pkg::out_t                  out_data;
	logic                           cfg_we = 1'b0;
	logic [twt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [twt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	windowed_outlier_rejecting_tracker_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Tracker state as the block should hold it.
	logic [twt_pkg::STAMP_W-1:0] trk_stamp [twt_pkg::DEPTH];
	logic [twt_pkg::PIX_W-1:0]   trk_x     [twt_pkg::DEPTH];
	logic [twt_pkg::PIX_W-1:0]   trk_w     [twt_pkg::DEPTH];
	int unsigned                 trk_oldest = 0;
	int unsigned                 trk_count = 0;
	logic [twt_pkg::PIX_W-1:0]   cur_frame_width = twt_pkg::FRAME_WIDTH_RST;
	logic [twt_pkg::STAMP_W-1:0] cur_window = twt_pkg::WINDOW_TICKS_RST;

	twt_pkg::out_t expected_tracks [$];
	int            error_count = 0;
	int            burst_left = 0;

	function automatic void queue_track(input twt_pkg::out_t r);
		expected_tracks = {expected_tracks, r};
	endfunction

	function automatic twt_pkg::out_t take_track();
		twt_pkg::out_t r;
		r = expected_tracks[0];
		expected_tracks.delete(0);
		return r;
	endfunction

	function automatic twt_pkg::out_t track_detection(input twt_pkg::in_t d);
		int unsigned                 p;
		int unsigned                 k;
		int unsigned                 n;
		int unsigned                 ni;
		longint                      sum;
		longint                      lim;
		longint                      sx;
		longint                      sw;
		longint                      dev;
		longint                      tgt;
		logic [twt_pkg::STAMP_W-1:0] age;
		twt_pkg::out_t               r;
		if (trk_count >= twt_pkg::DEPTH) begin
			p = trk_oldest;
			trk_oldest = (trk_oldest + 1) % twt_pkg::DEPTH;
		end else begin
			p = (trk_oldest + trk_count) % twt_pkg::DEPTH;
			trk_count++;
		end
		trk_stamp[p] = d.stamp;
		trk_x[p] = d.left_x;
		trk_w[p] = d.obj_width;
		age = d.stamp - trk_stamp[trk_oldest];
		while (trk_count > 0 && age > cur_window) begin
			trk_oldest = (trk_oldest + 1) % twt_pkg::DEPTH;
			trk_count--;
			age = d.stamp - trk_stamp[trk_oldest];
		end
		n = trk_count;
		sum = 0;
		for (k = 0; k < n; k++)
			sum += longint'(trk_x[(trk_oldest + k) % twt_pkg::DEPTH]);
		lim = longint'(cur_frame_width / 5) * longint'(n);
		sx = 0;
		sw = 0;
		ni = 0;
		for (k = 0; k < n; k++) begin
			p = (trk_oldest + k) % twt_pkg::DEPTH;
			dev = longint'(n) * longint'(trk_x[p]) - sum;
			if (dev < 0)
				dev = -dev;
			if (dev < lim) begin
				sx += longint'(trk_x[p]);
				sw += longint'(trk_w[p]);
				ni++;
			end
		end
		tgt = -1;
		if (ni > 0)
			tgt = sx / longint'(ni) + (sw / longint'(ni)) / 2;
		r.target = tgt[twt_pkg::TGT_W-1:0];
		r.found = (ni > 0);
		r.kept_count = n[twt_pkg::OUT_CNT_W-1:0];
		r.inlier_count = ni[twt_pkg::OUT_CNT_W-1:0];
		return r;
	endfunction

	function automatic twt_pkg::in_t make_det(input logic [31:0] s, input int x, input int w);
		twt_pkg::in_t d;
		d.stamp = s;
		d.left_x = x[twt_pkg::PIX_W-1:0];
		d.obj_width = w[twt_pkg::PIX_W-1:0];
		return d;
	endfunction

	// Drives one detection, with a random gap between bursts, and predicts
	// its result at the edge where the beat is taken.
	task automatic send_detection(input twt_pkg::in_t d);
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 18)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
		@(negedge clk);
		in_data <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		queue_track(track_detection(d));
		burst_left--;
	endtask

	// Holds off the sender until every result is back and the block is idle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_tracks.size() == 0);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(input logic [twt_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == twt_pkg::REG_FRAME_WIDTH)
			cur_frame_width = val[twt_pkg::PIX_W-1:0];
		else if (idx == twt_pkg::REG_WINDOW_TICKS)
			cur_window = val;
	endtask

	// Receiver stall pattern: it switches between free running, random,
	// periodic and long-run stalling.
	int stall_mode = 0;
	int mode_left = 0;
	int run_left = 0;
	int cyc = 0;
	logic stall_hold = 1'b0;
	always @(negedge clk) begin
		cyc++;
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(30, 200);
		end
		mode_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= (cyc % 7) < 3;
			default: begin
				if (run_left == 0) begin
					stall_hold = ~stall_hold;
					run_left = stall_hold ? $urandom_range(1, 40) : $urandom_range(1, 10);
				end
				run_left--;
				out_stall <= stall_hold;
			end
		endcase
	end

	always @(posedge clk) begin
		twt_pkg::out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tracks.size() == 0) begin
				if (error_count < 10)
					$display("unexpected result: target %0d found %0d kept %0d inliers %0d",
					         out_data.target, out_data.found, out_data.kept_count,
					         out_data.inlier_count);
				error_count++;
			end else begin
				e = take_track();
				if (out_data.target !== e.target || out_data.found !== e.found ||
				    out_data.kept_count !== e.kept_count ||
				    out_data.inlier_count !== e.inlier_count) begin
					if (error_count < 10)
						$display("mismatch: target %0d/%0d found %0d/%0d kept %0d/%0d inliers %0d/%0d (exp/act)",
						         e.target, out_data.target, e.found, out_data.found,
						         e.kept_count, out_data.kept_count,
						         e.inlier_count, out_data.inlier_count);
					error_count++;
				end
			end
		end
	end

	task automatic test_single_and_extremes();
		send_detection(make_det(32'd0, 0, 0));
		send_detection(make_det(32'd10, 4095, 4095));
		send_detection(make_det(32'd11, 4095, 0));
		send_detection(make_det(32'd12, 0, 4095));
	endtask

	// Sixteen entries in the window, after the four already stored, force the oldest ones to be overwritten.
	task automatic test_store_overwrite();
		int i;
		for (i = 0; i < 16; i++)
			send_detection(make_det(32'd100 + i, 2000 + i * 3, 100 + i));
	endtask

	task automatic test_expiry_and_wrap();
		send_detection(make_det(32'd5000000, 1234, 56));
		settle();
		write_reg(twt_pkg::REG_WINDOW_TICKS, 32'd1);
		send_detection(make_det(32'hFFFF_FFFF, 10, 10));
		send_detection(make_det(32'd0, 12, 10));
		send_detection(make_det(32'd2, 14, 10));
	endtask

	task automatic test_limit_zero();
		settle();
		write_reg(twt_pkg::REG_FRAME_WIDTH, 32'd4);
		send_detection(make_det(32'd3, 100, 100));
	endtask

	task automatic test_config_extremes();
		settle();
		write_reg(twt_pkg::REG_FRAME_WIDTH, 32'd4095);
		write_reg(twt_pkg::REG_WINDOW_TICKS, 32'hFFFF_FFFF);
		send_detection(make_det(32'h8000_0000, 4095, 4095));
		send_detection(make_det(32'h0000_0001, 0, 4095));
	endtask

	task automatic test_random_tracks();
		int          fw_list  [9] = '{640, 4095, 1, 5, 4, 320, 2000, 100, 0};
		logic [31:0] win_list [9] = '{100, 1000, 50, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		                              30, 5000, 0};
		int          div_list [9] = '{8, 16, 4, 1, 4, 1, 2, 64, 8};
		int          ph;
		int          i;
		int          r;
		int          fw;
		int          spread;
		int          center;
		int          xv;
		int          wv;
		logic [31:0] win;
		logic [31:0] step_max;
		logic [31:0] stamp_now;
		for (ph = 0; ph < 9; ph++) begin
			fw = fw_list[ph];
			win = win_list[ph];
			if (ph == 8) begin
				fw = $urandom_range(1, 4095);
				win = $urandom_range(1, 2000);
			end
			settle();
			write_reg(twt_pkg::REG_FRAME_WIDTH, fw);
			write_reg(twt_pkg::REG_WINDOW_TICKS, win);
			step_max = win / div_list[ph];
			if (step_max == 0)
				step_max = 1;
			spread = 2 * (fw / 5) + 1;
			center = $urandom_range(0, 4095);
			stamp_now = (ph == 1) ? 32'hFFFF_FF00 : $urandom;
			for (i = 0; i < 175; i++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					// Noise: every field fully random.
					send_detection(make_det($urandom, $urandom_range(0, 4095),
					                        $urandom_range(0, 4095)));
				end else begin
					if (r < 12)
						stamp_now = stamp_now + win + 1 + $urandom_range(0, 1000);
					else if (r >= 18)
						stamp_now = stamp_now + $urandom_range(0, step_max);
					if ($urandom_range(0, 29) == 0)
						center = $urandom_range(0, 4095);
					if (r >= 18 && r < 26)
						xv = $urandom_range(0, 4095);
					else
						xv = center + $urandom_range(0, 2 * spread) - spread;
					if (xv < 0)
						xv = 0;
					if (xv > 4095)
						xv = 4095;
					wv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
					                                : $urandom_range(20, 300);
					send_detection(make_det(stamp_now, xv, wv));
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);
		test_single_and_extremes();
		test_store_overwrite();
		test_expiry_and_wrap();
		test_limit_zero();
		test_config_extremes();
		test_random_tracks();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_tracks.size() == 0);
		repeat (200) @(negedge clk);
		if (expected_tracks.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(4 * 1500000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
rtl/core/twt_pkg.sv
rtl/core/twt_div.sv
rtl/core/twt_dp.sv
rtl/core/twt_ctrl.sv
rtl/core/windowed_outlier_rejecting_tracker_top.sv
bench/windowed_outlier_rejecting_tracker_top_tb.sv
